// ===== hw/rtl/s5scan_pkg.sv =====
// Shared types, constants and byte tables for the S5 sleep-type scanner.
`default_nettype none

package s5scan_pkg;

    // Default length of the search window, in bytes, counted from the start of an _S5_ name.
    localparam int unsigned SEARCH_WINDOW_DEF = 64;

    // AML and table constants.
    localparam logic [7:0] NAME_UNDERSCORE = 8'h5F;
    localparam logic [7:0] NAME_S          = 8'h53;
    localparam logic [7:0] NAME_5          = 8'h35;
    localparam logic [7:0] OP_PACKAGE      = 8'h12;
    localparam logic [7:0] PREFIX_BYTE     = 8'h0A;
    localparam logic [7:0] SIG_D           = 8'h44;
    localparam logic [7:0] SIG_S           = 8'h53;
    localparam logic [7:0] SIG_T           = 8'h54;

    // Signature bytes seen so far saturate at this count.
    localparam logic [2:0] HDR_LEN = 3'd4;

    typedef enum logic [3:0] {
        PH_SCAN,
        PH_LEAD,
        PH_FOLLOW,
        PH_COUNT,
        PH_PREFA,
        PH_VALA,
        PH_PREFB,
        PH_VALB,
        PH_DONE
    } s5scan_phase_t;

    typedef struct packed {
        logic       s5_found;
        logic [7:0] sleep_type_a;
        logic [7:0] sleep_type_b;
        logic       checksum_ok;
        logic       signature_ok;
    } s5scan_result_t;

    // Expected byte of the name _S5_ at a given match position.
    function automatic logic [7:0] name_byte(input logic [1:0] pos);
        logic [7:0] val;
        unique case (pos)
            2'd0:    val = NAME_UNDERSCORE;
            2'd1:    val = NAME_S;
            2'd2:    val = NAME_5;
            default: val = NAME_UNDERSCORE;
        endcase
        return val;
    endfunction

    // Expected byte of the table signature DSDT at a given header position.
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] val;
        unique case (pos)
            2'd0:    val = SIG_D;
            2'd1:    val = SIG_S;
            2'd2:    val = SIG_D;
            default: val = SIG_T;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/s5scan_core.sv =====
// Per-byte scan state: checksum, signature, name match and package parser.
`default_nettype none

module s5scan_core #(
    parameter int unsigned SEARCH_WINDOW = s5scan_pkg::SEARCH_WINDOW_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       last_byte,
    output s5scan_pkg::s5scan_result_t      result
);

    localparam int unsigned WIN_W = $clog2(SEARCH_WINDOW);
    localparam logic [WIN_W-1:0] WIN_RELOAD = WIN_W'(SEARCH_WINDOW - 4);

    s5scan_pkg::s5scan_phase_t phase_reg, phase_next;
    logic [1:0]       match_reg, match_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [1:0]       follow_reg, follow_next;
    logic [7:0]       sum_reg, sum_next;
    logic [2:0]       hdr_reg, hdr_next;
    logic             sig_reg, sig_next;
    logic             pkg_reg, pkg_next;
    logic [7:0]       type_a_reg, type_a_next;
    logic [7:0]       type_b_reg, type_b_next;

    logic       win_open;
    logic       take_package;
    logic [1:0] follow_dec;
    logic       checksum_ok;
    logic       signature_ok;
    logic       found;

    assign win_open     = (win_reg != '0);
    assign take_package = win_open && (data_byte == s5scan_pkg::OP_PACKAGE);
    assign follow_dec   = follow_reg - 2'd1;

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            s5scan_pkg::PH_SCAN:
                if (take_package)
                    phase_next = s5scan_pkg::PH_LEAD;
            s5scan_pkg::PH_LEAD:
                phase_next = (data_byte[7:6] != 2'd0) ? s5scan_pkg::PH_FOLLOW
                                                      : s5scan_pkg::PH_COUNT;
            s5scan_pkg::PH_FOLLOW:
                if (follow_dec == 2'd0)
                    phase_next = s5scan_pkg::PH_COUNT;
            s5scan_pkg::PH_COUNT:
                phase_next = s5scan_pkg::PH_PREFA;
            s5scan_pkg::PH_PREFA:
                phase_next = (data_byte == s5scan_pkg::PREFIX_BYTE) ? s5scan_pkg::PH_VALA
                                                                    : s5scan_pkg::PH_DONE;
            s5scan_pkg::PH_VALA:
                phase_next = s5scan_pkg::PH_PREFB;
            s5scan_pkg::PH_PREFB:
                phase_next = (data_byte == s5scan_pkg::PREFIX_BYTE) ? s5scan_pkg::PH_VALB
                                                                    : s5scan_pkg::PH_DONE;
            default:
                phase_next = s5scan_pkg::PH_DONE;
        endcase
    end

    // Datapath updates that depend on the phase.
    always_comb
    begin
        match_next  = match_reg;
        win_next    = win_reg;
        follow_next = follow_reg;
        pkg_next    = pkg_reg;
        type_a_next = type_a_reg;
        type_b_next = type_b_reg;

        unique case (phase_reg)
            s5scan_pkg::PH_SCAN:
            begin
                if (!take_package)
                begin
                    if (win_open)
                        win_next = win_reg - WIN_W'(1);
                    if (data_byte == s5scan_pkg::name_byte(match_reg))
                    begin
                        if (match_reg == 2'd3)
                        begin
                            win_next   = WIN_RELOAD;
                            match_next = 2'd1;
                        end
                        else
                            match_next = match_reg + 2'd1;
                    end
                    else
                        match_next = (data_byte == s5scan_pkg::NAME_UNDERSCORE) ? 2'd1 : 2'd0;
                end
            end
            s5scan_pkg::PH_LEAD:   follow_next = data_byte[7:6];
            s5scan_pkg::PH_FOLLOW: follow_next = follow_dec;
            s5scan_pkg::PH_COUNT:  pkg_next = 1'b1;
            s5scan_pkg::PH_VALA:   type_a_next = data_byte;
            s5scan_pkg::PH_VALB:   type_b_next = data_byte;
            default:               pkg_next = pkg_reg;
        endcase
    end

    // The checksum runs on every byte and the signature check on the header bytes, regardless of phase.
    always_comb
    begin
        sum_next = sum_reg + data_byte;
        hdr_next = hdr_reg;
        sig_next = sig_reg;
        if (hdr_reg != s5scan_pkg::HDR_LEN)
        begin
            if (data_byte != s5scan_pkg::sig_byte(hdr_reg[1:0]))
                sig_next = 1'b0;
            hdr_next = hdr_reg + 3'd1;
        end
    end

    assign checksum_ok  = (sum_next == 8'd0);
    assign signature_ok = sig_next && (hdr_next == s5scan_pkg::HDR_LEN);
    assign found        = checksum_ok && signature_ok && pkg_next;

    assign result.s5_found     = found;
    assign result.sleep_type_a = found ? type_a_next : 8'd0;
    assign result.sleep_type_b = found ? type_b_next : 8'd0;
    assign result.checksum_ok  = checksum_ok;
    assign result.signature_ok = signature_ok;

    // The last byte of a table returns every field to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= s5scan_pkg::PH_SCAN;
            match_reg  <= 2'd0;
            win_reg    <= '0;
            follow_reg <= 2'd0;
            sum_reg    <= 8'd0;
            hdr_reg    <= 3'd0;
            sig_reg    <= 1'b1;
            pkg_reg    <= 1'b0;
            type_a_reg <= 8'd0;
            type_b_reg <= 8'd0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg  <= s5scan_pkg::PH_SCAN;
                match_reg  <= 2'd0;
                win_reg    <= '0;
                follow_reg <= 2'd0;
                sum_reg    <= 8'd0;
                hdr_reg    <= 3'd0;
                sig_reg    <= 1'b1;
                pkg_reg    <= 1'b0;
                type_a_reg <= 8'd0;
                type_b_reg <= 8'd0;
            end
            else
            begin
                phase_reg  <= phase_next;
                match_reg  <= match_next;
                win_reg    <= win_next;
                follow_reg <= follow_next;
                sum_reg    <= sum_next;
                hdr_reg    <= hdr_next;
                sig_reg    <= sig_next;
                pkg_reg    <= pkg_next;
                type_a_reg <= type_a_next;
                type_b_reg <= type_b_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/s5scan_out.sv =====
// Result register with valid/ready handshake toward the receiver.
`default_nettype none

module s5scan_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire s5scan_pkg::s5scan_result_t result,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic                            can_load,
    output s5scan_pkg::s5scan_result_t      held
);

    logic valid_reg;
    s5scan_pkg::s5scan_result_t held_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            held_reg <= result;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/aml_s5_sleep_type_scanner.sv =====
// Top level of the DSDT _S5_ sleep-type scanner.
//
// The input channel (in_valid/in_ready) carries one table byte per item in
// data_byte, with last_byte set on the final byte of a table. The scanner
// sums the bytes, checks the DSDT signature, finds the _S5_ name and its
// package, and captures up to two byte-prefixed sleep type values.
// The output channel (out_valid/out_ready) carries exactly one result item per
// table, produced by the last byte: s5_found, sleep_type_a, sleep_type_b,
// checksum_ok and signature_ok. Bytes without last_byte produce nothing.
// Throughput is one byte per cycle while no last byte stalls. An accepted
// byte is held in the input register and is folded into the scan state when
// it leaves it; a last byte loads the result register at that same edge,
// which raises out_valid. The result register decouples the two sides:
// while a result waits, bytes of the next table keep flowing; only a second
// last byte stalls in the input register, holding in_ready low until the
// waiting result is taken.
// Reset clears the scan state, the input valid flag and the result valid flag;
// after the final byte the scan state returns to its reset values by itself.
`default_nettype none

module aml_s5_sleep_type_scanner #(
    parameter int unsigned SEARCH_WINDOW = s5scan_pkg::SEARCH_WINDOW_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            s5_found,
    output logic [7:0]      sleep_type_a,
    output logic [7:0]      sleep_type_b,
    output logic            checksum_ok,
    output logic            signature_ok
);

    // Input register holding one byte ahead of the scan state.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic step;
    logic can_load;
    s5scan_pkg::s5scan_result_t step_result;
    s5scan_pkg::s5scan_result_t held_result;

    // A byte that ends a table needs room in the result register; any other
    // byte is consumed unconditionally.
    assign step     = in_valid_reg && (!in_last_reg || can_load);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    s5scan_core #(
        .SEARCH_WINDOW(SEARCH_WINDOW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (step_result)
    );

    s5scan_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && in_last_reg),
        .result    (step_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .held      (held_result)
    );

    assign s5_found     = held_result.s5_found;
    assign sleep_type_a = held_result.sleep_type_a;
    assign sleep_type_b = held_result.sleep_type_b;
    assign checksum_ok  = held_result.checksum_ok;
    assign signature_ok = held_result.signature_ok;

endmodule

`default_nettype wire
